[src/mrde_pkg.sv]
// mrde_pkg: shared constants, command and result codes, types and helpers
// for the radius directed equalizer core. No dependencies.
package mrde_pkg;

  localparam int MAX_TAPS   = 32;
  localparam int MAX_RADII  = 16;
  localparam int LINE_DEPTH = MAX_TAPS + 1;
  localparam int TAP_IDX_W  = $clog2(MAX_TAPS);
  localparam int RAD_IDX_W  = $clog2(MAX_RADII);
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int CNT_W      = LINE_AW;
  localparam int NCH        = 4;
  localparam int SMP_W      = 16;
  localparam int TAP_W      = 24;
  localparam int TAP_AW     = 2 + TAP_IDX_W;
  localparam int TAP_WORD_W = NCH * TAP_W;
  localparam int LINE_W     = NCH * SMP_W;
  localparam int ERR_W      = 33;
  localparam int PWR_W      = 32;
  localparam int PROD_W     = TAP_W + SMP_W;
  localparam int ACC_W      = PROD_W + 7;
  localparam int EO_W       = ERR_W + SMP_W;
  localparam int M_W        = EO_W + SMP_W;
  localparam int P_W        = M_W + SMP_W;
  localparam int CMD_W      = 3;
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 5;
  localparam int TC_W       = 6;
  localparam int RC_W       = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CMD_W-1:0] CMD_SAMPLE      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_TAP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_STEP   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD_RADIUS = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_TAP    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RESTART     = 3'd5;

  localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRANS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TAP    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_COUNT = 1'd1;

  localparam logic [TC_W-1:0] TAP_COUNT_RST    = 6'd16;
  localparam logic [RC_W-1:0] RADIUS_COUNT_RST = 5'd3;

  typedef struct packed {
    logic                        en;
    logic [RAD_IDX_W-1:0]        idx;
    logic signed [SMP_W-1:0]     value;
  } rad_wr_t;

  function automatic logic signed [SMP_W-1:0] sat_to16(input logic signed [TAP_W-1:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > 24'sd32767) begin
      r = 16'sd32767;
    end else if (v < -24'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

[src/mrde_if.sv]
// request, result and register write channels of the equalizer core
// depends on mrde_pkg
interface mrde_in_if import mrde_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [SMP_W-1:0]  sample_xr;
  logic signed [SMP_W-1:0]  sample_xi;
  logic signed [SMP_W-1:0]  sample_yr;
  logic signed [SMP_W-1:0]  sample_yi;
  logic [1:0]               row;
  logic [1:0]               col;
  logic [IDX_W-1:0]         entry_index;
  logic signed [TAP_W-1:0]  load_value;
  modport source(output valid, cmd, sample_xr, sample_xi, sample_yr, sample_yi, row, col,
                 entry_index, load_value, input ready);
  modport sink(input valid, cmd, sample_xr, sample_xi, sample_yr, sample_yi, row, col,
               entry_index, load_value, output ready);
endinterface

interface mrde_out_if import mrde_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [SMP_W-1:0]  out_xr;
  logic signed [SMP_W-1:0]  out_xi;
  logic signed [SMP_W-1:0]  out_yr;
  logic signed [SMP_W-1:0]  out_yi;
  logic signed [ERR_W-1:0]  err_x;
  logic signed [ERR_W-1:0]  err_y;
  logic signed [TAP_W-1:0]  tap_value;
  modport source(output valid, kind, out_xr, out_xi, out_yr, out_yi, err_x, err_y,
                 tap_value, input ready);
  modport sink(input valid, kind, out_xr, out_xi, out_yr, out_yi, err_x, err_y,
               tap_value, output ready);
endinterface

interface mrde_cfg_if import mrde_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[src/mrde_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module mrde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mrde_radius.sv]
// mrde_radius: radius table and nearest radius search, one entry per cycle
// for both polarizations, then the radius error; depends on mrde_pkg
module mrde_radius import mrde_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rad_wr_t                  wr,
  input  logic                     start,
  input  logic [RC_W-1:0]          nr,
  input  logic [PWR_W-1:0]         p_x,
  input  logic [PWR_W-1:0]         p_y,
  output logic                     done,
  output logic signed [ERR_W-1:0]  err_x,
  output logic signed [ERR_W-1:0]  err_y
);

  logic signed [SMP_W-1:0] tbl [MAX_RADII];
  logic [RAD_IDX_W-1:0]    rj_r;
  logic                    run_r;
  logic                    fin_r;
  logic                    done_r;
  logic signed [SMP_W-1:0] best_x_r;
  logic signed [SMP_W-1:0] best_y_r;
  logic signed [SMP_W-1:0] cand;
  logic [RAD_IDX_W-1:0]    last_idx;
  logic signed [2*SMP_W-1:0] sq_x;
  logic signed [2*SMP_W-1:0] sq_y;

  // true when b lies strictly nearer to sqrt(p) than a
  function automatic logic nearer(input logic signed [SMP_W-1:0] a,
                                  input logic signed [SMP_W-1:0] b,
                                  input logic [PWR_W-1:0] p);
    logic signed [SMP_W:0]     s;
    logic signed [2*SMP_W+1:0] sq;
    logic [PWR_W+1:0]          p4;
    logic                      r;
    s  = $signed({a[SMP_W-1], a}) + $signed({b[SMP_W-1], b});
    sq = s * s;
    p4 = {p, 2'b00};
    if (a > b) begin
      r = (s > 0) && ($unsigned(sq) > p4);
    end else if (a < b) begin
      r = (s < 0) || ($unsigned(sq) < p4);
    end else begin
      r = 1'b0;
    end
    return r;
  endfunction

  assign cand     = tbl[rj_r];
  assign last_idx = RAD_IDX_W'(nr - RC_W'(1));
  assign sq_x     = best_x_r * best_x_r;
  assign sq_y     = best_y_r * best_y_r;
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tbl[wr.idx] <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && rj_r == last_idx) begin
        run_r <= 1'b0;
        fin_r <= 1'b1;
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rj_r <= '0;
    end else if (run_r) begin
      rj_r <= rj_r + RAD_IDX_W'(1);
      // first entry seeds the search, ties keep the earlier entry
      if (rj_r == '0 || nearer(best_x_r, cand, p_x)) begin
        best_x_r <= cand;
      end
      if (rj_r == '0 || nearer(best_y_r, cand, p_y)) begin
        best_y_r <= cand;
      end
    end
    if (fin_r) begin
      err_x <= $signed({1'b0, sq_x}) - $signed({1'b0, p_x});
      err_y <= $signed({1'b0, sq_y}) - $signed({1'b0, p_y});
    end
  end

endmodule

[src/mimo_radius_directed_equalizer_core.sv]
// Radially directed 4x4 real adaptive equaliser for dual-polarisation samples at two
// samples per symbol. Taps live in a 128 x 96 ram (one word holds the four output rows
// of a column and tap), the sample history in a 33 entry ring ram. A sample that gives
// no result, a step or radius load and a restart return straight to idle; a tap load
// passes a tap read and a tap write state, and a tap read then emits its result.
// A symbol output filters, drains, registers outputs and powers and waits on the radius
// search; a transition output is followed by a tap update. The filter walks one tap word
// per cycle through four multipliers; the update forms the step product once per tap,
// then reads, modifies and writes back each tap word in turn.
// depends on mrde_pkg, mrde_if, mrde_ram and mrde_radius
module mimo_radius_directed_equalizer_core import mrde_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  mrde_in_if.sink   in_req,
  mrde_out_if.source out_res,
  mrde_cfg_if.sink  cfg_wr
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FILT   = 4'd1;
  localparam logic [3:0] S_FDRAIN = 4'd2;
  localparam logic [3:0] S_YREG   = 4'd3;
  localparam logic [3:0] S_PWR    = 4'd4;
  localparam logic [3:0] S_RGO    = 4'd5;
  localparam logic [3:0] S_RWAIT  = 4'd6;
  localparam logic [3:0] S_TRD    = 4'd7;
  localparam logic [3:0] S_TWR    = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;
  localparam logic [3:0] S_EO     = 4'd10;
  localparam logic [3:0] S_ADM    = 4'd11;
  localparam logic [3:0] S_ADA    = 4'd12;
  localparam logic [3:0] S_ADB    = 4'd13;

  logic [3:0] state_r, state_nxt;

  logic [TC_W-1:0]      tap_count_r;
  logic [RC_W-1:0]      radius_count_r;
  logic [CNT_W-1:0]     nf, start_idx;
  logic [RC_W-1:0]      nr;

  logic [LINE_AW-1:0]   wp_r, wp_inc;
  logic [CNT_W-1:0]     fill_r;
  logic                 odd_r, pend_v_r, is_sym_r, sym_go;
  logic                 in_acc, emit_fire, last_fc;

  logic [CMD_W-1:0]     cmd_r;
  logic [1:0]           row_r, col_r;
  logic [IDX_W-1:0]     idx_r;
  logic signed [TAP_W-1:0] val_r;

  logic [TAP_IDX_W-1:0] j_r;
  logic [1:0]           c_r, c1_r, csel;
  logic                 v1_r, v2_r, zq_r, zflag;
  logic [CNT_W-1:0]     age;
  logic [LINE_AW:0]     diff;

  logic                    line_we;
  logic [LINE_AW-1:0]      line_raddr;
  logic [LINE_W-1:0]       line_wdata, line_rdata;
  logic signed [SMP_W-1:0] samp_sel;

  logic                    tap_we;
  logic [TAP_AW-1:0]       tap_raddr, tap_waddr;
  logic [TAP_WORD_W-1:0]   tap_wdata, tap_rdata, tap_merge, tap_upd;

  logic signed [PROD_W-1:0] prod_r [NCH];
  logic signed [ACC_W-1:0]  acc_r  [NCH];
  logic signed [SMP_W-1:0]  ysat   [NCH];
  logic signed [SMP_W-1:0]  y_r    [NCH];
  logic signed [SMP_W-1:0]  pend_y_r [NCH];
  logic signed [ERR_W-1:0]  pend_ex_r, pend_ey_r;
  logic signed [EO_W-1:0]   eo_r [NCH];
  logic signed [M_W-1:0]    m_r  [NCH];
  logic signed [P_W-1:0]    p_r  [NCH];
  logic signed [SMP_W-1:0]  step_tbl [MAX_TAPS];
  logic signed [2*SMP_W-1:0] sq0, sq1, sq2, sq3;
  logic [PWR_W-1:0]         px_r, py_r;
  logic signed [TAP_W-1:0]  tap_sel_r;

  rad_wr_t                  rad_wr;
  logic                     rad_done;
  logic signed [ERR_W-1:0]  rad_err_x, rad_err_y;

  logic                     out_v_r;
  logic [KIND_W-1:0]        kind_r;
  logic signed [SMP_W-1:0]  o_y_r [NCH];
  logic signed [ERR_W-1:0]  o_ex_r, o_ey_r;
  logic signed [TAP_W-1:0]  o_tap_r;

  // effective counts
  always_comb begin
    if (tap_count_r == '0) begin
      nf = CNT_W'(1);
    end else if (tap_count_r > TC_W'(MAX_TAPS)) begin
      nf = CNT_W'(MAX_TAPS);
    end else begin
      nf = tap_count_r;
    end
    if (radius_count_r == '0) begin
      nr = RC_W'(1);
    end else if (radius_count_r > RC_W'(MAX_RADII)) begin
      nr = RC_W'(MAX_RADII);
    end else begin
      nr = radius_count_r;
    end
    start_idx = (nf - CNT_W'(1)) | CNT_W'(1);
  end

  assign in_req.ready = (state_r == S_IDLE);
  assign cfg_wr.ready = 1'b1;
  assign in_acc       = in_req.valid && in_req.ready;
  assign sym_go       = odd_r && (fill_r >= start_idx);
  assign emit_fire    = (state_r == S_EMIT) && (!out_v_r || out_res.ready);
  assign last_fc      = (c_r == 2'd3) && ({1'b0, j_r} == nf - CNT_W'(1));
  assign wp_inc       = (wp_r == LINE_AW'(LINE_DEPTH - 1)) ? '0 : wp_r + LINE_AW'(1);

  // sample ring: age 0 is the newest sample, ages at or beyond the fill read as zero
  always_comb begin
    if (state_r == S_ADM || state_r == S_ADA || state_r == S_ADB) begin
      age = nf - {1'b0, j_r};
    end else begin
      age = nf - CNT_W'(1) - {1'b0, j_r};
    end
    diff = {1'b0, wp_r} - {1'b0, age};
    if (diff[LINE_AW]) begin
      diff = diff + (LINE_AW + 1)'(LINE_DEPTH);
    end
    line_raddr = diff[LINE_AW-1:0];
    zflag      = (age >= fill_r);
  end

  assign line_we    = in_acc && (in_req.cmd == CMD_SAMPLE);
  assign line_wdata = {in_req.sample_yi, in_req.sample_yr, in_req.sample_xi, in_req.sample_xr};

  mrde_ram #(.WIDTH(LINE_W), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (wp_inc),
    .wdata (line_wdata),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  assign csel     = (state_r == S_ADA) ? c_r : c1_r;
  assign samp_sel = zq_r ? '0 : $signed(line_rdata[csel*SMP_W +: SMP_W]);

  // tap word update: round half up from 2^-72 to 2^-20, then saturate
  always_comb begin
    logic signed [P_W:0]     pr;
    logic signed [P_W-53:0]  dl;
    logic signed [TAP_W+6:0] nt;
    logic signed [TAP_W-1:0] t;
    tap_upd   = '0;
    tap_merge = tap_rdata;
    for (int r = 0; r < NCH; r++) begin
      t  = $signed(tap_rdata[r*TAP_W +: TAP_W]);
      pr = $signed({p_r[r][P_W-1], p_r[r]}) + $signed({(P_W-51)'(1), 51'b0});
      dl = pr[P_W-1:52];
      nt = $signed({{7{t[TAP_W-1]}}, t}) + $signed({{2{dl[P_W-53]}}, dl});
      if (nt > 31'sd8388607) begin
        tap_upd[r*TAP_W +: TAP_W] = 24'h7fffff;
      end else if (nt < -31'sd8388608) begin
        tap_upd[r*TAP_W +: TAP_W] = 24'h800000;
      end else begin
        tap_upd[r*TAP_W +: TAP_W] = nt[TAP_W-1:0];
      end
      if (2'(r) == row_r) begin
        tap_merge[r*TAP_W +: TAP_W] = val_r;
      end
    end
  end

  assign tap_raddr = (state_r == S_TRD) ? {col_r, idx_r} : {c_r, j_r};
  assign tap_waddr = (state_r == S_TWR) ? {col_r, idx_r} : {c_r, j_r};
  assign tap_wdata = (state_r == S_TWR) ? tap_merge : tap_upd;
  assign tap_we    = ((state_r == S_TWR) && (cmd_r == CMD_LOAD_TAP)) || (state_r == S_ADB);

  mrde_ram #(.WIDTH(TAP_WORD_W), .DEPTH(1 << TAP_AW)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_wdata),
    .raddr (tap_raddr),
    .rdata (tap_rdata)
  );

  // filter output rounding and saturation
  always_comb begin
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] sh;
    for (int r = 0; r < NCH; r++) begin
      rnd = acc_r[r] + $signed({(ACC_W-20)'(1), 19'b0});
      sh  = rnd >>> 20;
      if (sh > 47'sd32767) begin
        ysat[r] = 16'sd32767;
      end else if (sh < -47'sd32768) begin
        ysat[r] = -16'sd32768;
      end else begin
        ysat[r] = sh[SMP_W-1:0];
      end
    end
  end

  assign sq0 = y_r[0] * y_r[0];
  assign sq1 = y_r[1] * y_r[1];
  assign sq2 = y_r[2] * y_r[2];
  assign sq3 = y_r[3] * y_r[3];

  always_comb begin
    rad_wr.en    = in_acc && (in_req.cmd == CMD_LOAD_RADIUS) &&
                   (in_req.entry_index < IDX_W'(MAX_RADII));
    rad_wr.idx   = in_req.entry_index[RAD_IDX_W-1:0];
    rad_wr.value = sat_to16(in_req.load_value);
  end

  mrde_radius u_radius (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (rad_wr),
    .start (state_r == S_RGO),
    .nr    (nr),
    .p_x   (px_r),
    .p_y   (py_r),
    .done  (rad_done),
    .err_x (rad_err_x),
    .err_y (rad_err_y)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req.cmd)
            CMD_SAMPLE:   state_nxt = (pend_v_r || sym_go) ? S_FILT : S_IDLE;
            CMD_LOAD_TAP: state_nxt = S_TRD;
            CMD_READ_TAP: state_nxt = S_TRD;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_FILT:   state_nxt = last_fc ? S_FDRAIN : S_FILT;
      S_FDRAIN: state_nxt = (!v1_r && !v2_r) ? S_YREG : S_FDRAIN;
      S_YREG:   state_nxt = is_sym_r ? S_PWR : S_EMIT;
      S_PWR:    state_nxt = S_RGO;
      S_RGO:    state_nxt = S_RWAIT;
      S_RWAIT:  state_nxt = rad_done ? S_EMIT : S_RWAIT;
      S_TRD:    state_nxt = S_TWR;
      S_TWR:    state_nxt = (cmd_r == CMD_READ_TAP) ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (emit_fire) begin
          state_nxt = (cmd_r == CMD_READ_TAP || is_sym_r) ? S_IDLE : S_EO;
        end
      end
      S_EO:     state_nxt = S_ADM;
      S_ADM:    state_nxt = S_ADA;
      S_ADA:    state_nxt = S_ADB;
      S_ADB:    state_nxt = last_fc ? S_IDLE : ((c_r == 2'd3) ? S_ADM : S_ADA);
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      wp_r           <= '0;
      fill_r         <= '0;
      odd_r          <= 1'b0;
      pend_v_r       <= 1'b0;
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      out_v_r        <= 1'b0;
      tap_count_r    <= TAP_COUNT_RST;
      radius_count_r <= RADIUS_COUNT_RST;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == S_FILT);
      v2_r    <= v1_r;
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (cfg_wr.index)
          CFG_TAP_COUNT:    tap_count_r    <= cfg_wr.data;
          CFG_RADIUS_COUNT: radius_count_r <= cfg_wr.data[RC_W-1:0];
          default: ;
        endcase
      end
      if (emit_fire) begin
        out_v_r <= 1'b1;
      end else if (out_res.ready) begin
        out_v_r <= 1'b0;
      end
      if (in_acc) begin
        case (in_req.cmd)
          CMD_SAMPLE: begin
            wp_r     <= wp_inc;
            fill_r   <= (fill_r == CNT_W'(LINE_DEPTH)) ? fill_r : fill_r + CNT_W'(1);
            odd_r    <= ~odd_r;
            pend_v_r <= pend_v_r ? 1'b0 : sym_go;
          end
          CMD_RESTART: begin
            fill_r   <= '0;
            odd_r    <= 1'b0;
            pend_v_r <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    zq_r <= zflag;
    if (in_acc) begin
      cmd_r    <= in_req.cmd;
      row_r    <= in_req.row;
      col_r    <= in_req.col;
      idx_r    <= in_req.entry_index;
      val_r    <= in_req.load_value;
      is_sym_r <= !pend_v_r;
      j_r      <= '0;
      c_r      <= '0;
      for (int r = 0; r < NCH; r++) begin
        acc_r[r] <= '0;
      end
      if (in_req.cmd == CMD_LOAD_STEP) begin
        step_tbl[in_req.entry_index] <= sat_to16(in_req.load_value);
      end
    end
    if (v1_r) begin
      for (int r = 0; r < NCH; r++) begin
        prod_r[r] <= $signed(tap_rdata[r*TAP_W +: TAP_W]) * samp_sel;
      end
    end
    if (v2_r) begin
      for (int r = 0; r < NCH; r++) begin
        acc_r[r] <= acc_r[r] + ACC_W'(prod_r[r]);
      end
    end
    case (state_r)
      S_FILT: begin
        c1_r <= c_r;
        c_r  <= c_r + 2'd1;
        if (c_r == 2'd3) begin
          j_r <= j_r + TAP_IDX_W'(1);
        end
      end
      S_YREG: begin
        y_r <= ysat;
      end
      S_PWR: begin
        px_r <= $unsigned(sq0) + $unsigned(sq1);
        py_r <= $unsigned(sq2) + $unsigned(sq3);
      end
      S_RWAIT: begin
        if (rad_done) begin
          pend_ex_r <= rad_err_x;
          pend_ey_r <= rad_err_y;
          pend_y_r  <= y_r;
        end
      end
      S_TWR: begin
        tap_sel_r <= $signed(tap_rdata[row_r*TAP_W +: TAP_W]);
      end
      S_EO: begin
        for (int r = 0; r < NCH; r++) begin
          eo_r[r] <= ((r < 2) ? pend_ex_r : pend_ey_r) * pend_y_r[r];
        end
        j_r <= '0;
        c_r <= '0;
      end
      S_ADM: begin
        for (int r = 0; r < NCH; r++) begin
          m_r[r] <= step_tbl[j_r] * eo_r[r];
        end
      end
      S_ADA: begin
        for (int r = 0; r < NCH; r++) begin
          p_r[r] <= m_r[r] * samp_sel;
        end
      end
      S_ADB: begin
        c_r <= c_r + 2'd1;
        if (c_r == 2'd3) begin
          j_r <= j_r + TAP_IDX_W'(1);
        end
      end
      default: ;
    endcase
    if (emit_fire) begin
      if (cmd_r == CMD_READ_TAP) begin
        kind_r  <= KIND_TAP;
        o_tap_r <= tap_sel_r;
        o_ex_r  <= '0;
        o_ey_r  <= '0;
        for (int r = 0; r < NCH; r++) begin
          o_y_r[r] <= '0;
        end
      end else begin
        kind_r  <= is_sym_r ? KIND_SYMBOL : KIND_TRANS;
        o_tap_r <= '0;
        o_ex_r  <= is_sym_r ? pend_ex_r : '0;
        o_ey_r  <= is_sym_r ? pend_ey_r : '0;
        o_y_r   <= y_r;
      end
    end
  end

  assign out_res.valid     = out_v_r;
  assign out_res.kind      = kind_r;
  assign out_res.out_xr    = o_y_r[0];
  assign out_res.out_xi    = o_y_r[1];
  assign out_res.out_yr    = o_y_r[2];
  assign out_res.out_yi    = o_y_r[3];
  assign out_res.err_x     = o_ex_r;
  assign out_res.err_y     = o_ey_r;
  assign out_res.tap_value = o_tap_r;

endmodule

[src/mrde_checker.sv]
// mrde_checker: result channel checks on the equalizer core ports
// depends on mrde_pkg; bound to mimo_radius_directed_equalizer_core
module mrde_checker import mrde_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [KIND_W-1:0]       out_kind,
  input logic signed [SMP_W-1:0] out_xr,
  input logic signed [SMP_W-1:0] out_xi,
  input logic signed [SMP_W-1:0] out_yr,
  input logic signed [SMP_W-1:0] out_yi,
  input logic signed [ERR_W-1:0] err_x,
  input logic signed [ERR_W-1:0] err_y,
  input logic signed [TAP_W-1:0] tap_value
);

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(err_x) &&
    $stable(out_xr) && $stable(tap_value))
    else $error("stalled result changed");

  a_err_sym_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_SYMBOL |-> err_x == '0 && err_y == '0)
    else $error("radius error on a non symbol result");

  a_tap_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TAP |->
    out_xr == '0 && out_xi == '0 && out_yr == '0 && out_yi == '0)
    else $error("tap read carries filter outputs");

  a_tap_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_TAP |-> tap_value == '0)
    else $error("tap value on a filter result");

endmodule

bind mimo_radius_directed_equalizer_core mrde_checker u_mrde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_kind  (out_res.kind),
  .out_xr    (out_res.out_xr),
  .out_xi    (out_res.out_xi),
  .out_yr    (out_res.out_yr),
  .out_yi    (out_res.out_yi),
  .err_x     (out_res.err_x),
  .err_y     (out_res.err_y),
  .tap_value (out_res.tap_value)
);

[sim/testbench.sv]
// testbench for the radius directed equaliser core: preloads every store, walks a
// directed table, then random request phases under several register settings
// depends on mrde_pkg, mrde_if and the equaliser core
`timescale 1ns / 1ps
module testbench;
  import mrde_pkg::*;

  localparam int PHASES      = 6;
  localparam int PER_PHASE   = 77;
  localparam int QUIET_TICKS = 300;
  localparam int HOLD_TICKS  = 600;
  localparam longint LIMIT   = 3000000;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [SMP_W-1:0] xr, xi, yr, yi;
    logic [1:0]              row, col;
    logic [IDX_W-1:0]        idx;
    logic signed [TAP_W-1:0] val;
  } eq_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [SMP_W-1:0] xr, xi, yr, yi;
    logic signed [ERR_W-1:0] ex, ey;
    logic signed [TAP_W-1:0] tap;
  } eq_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mrde_in_if  in_ch();
  mrde_out_if res_ch();
  mrde_cfg_if cfg_ch();

  mimo_radius_directed_equalizer_core dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_ch), .out_res(res_ch), .cfg_wr(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // equaliser shadow state
  shortint line_mem [LINE_DEPTH][4];
  int      tap_mem [16][MAX_TAPS];
  shortint step_mem [MAX_TAPS];
  shortint radius_mem [MAX_RADII];
  int      seen_cnt;
  bit      odd_ph;
  longint  held_err [2];
  shortint held_out [4];
  bit      held_valid;
  int      tap_cnt, radius_cnt;

  eq_res_t awaited_results [$];
  int  mismatches = 0;
  int  n_symbol = 0, n_trans = 0, n_tapread = 0, n_settings = 0;
  int  s_idle = 0, r_idle = 0;
  bit  hold_req = 1'b0;
  longint cycles = 0;

  function automatic longint clip(input longint v, input int w);
    longint lim;
    lim = longint'(1) << (w - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic int used_taps();
    if (tap_cnt < 1) return 1;
    if (tap_cnt > MAX_TAPS) return MAX_TAPS;
    return tap_cnt;
  endfunction

  function automatic int used_radii();
    if (radius_cnt < 1) return 1;
    if (radius_cnt > MAX_RADII) return MAX_RADII;
    return radius_cnt;
  endfunction

  function automatic void fir_out(output shortint y [4]);
    int nf;
    longint acc;
    nf = used_taps();
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int j = 0; j < nf; j++)
        for (int c = 0; c < 4; c++)
          acc += longint'(tap_mem[r*4+c][j]) * longint'(line_mem[nf-1-j][c]);
      y[r] = shortint'(clip((acc + (longint'(1) << 19)) >>> 20, 16));
    end
  endfunction

  // radius b strictly closer to sqrt(p) than radius a, compared without roots
  function automatic bit closer(input longint a, input longint b, input longint p);
    longint s;
    s = a + b;
    if (a > b) return s > 0 && s * s > 4 * p;
    if (a < b) return s < 0 || s * s < 4 * p;
    return 1'b0;
  endfunction

  function automatic longint ring_error(input longint p);
    int best;
    longint r;
    best = 0;
    for (int j = 1; j < used_radii(); j++)
      if (closer(radius_mem[best], radius_mem[j], p)) best = j;
    r = radius_mem[best];
    return r * r - p;
  endfunction

  // mu * e / 2^52 rounded half up, split so nothing overflows
  function automatic longint scaled_delta(input longint mu, input longint e);
    longint hi, lo, a, b, ahi, alo, c;
    hi = e >>> 32;
    lo = e - hi * 64'sd4294967296;
    a = mu * hi;
    b = mu * lo + (longint'(1) << 51);
    ahi = a >>> 20;
    alo = a - ahi * 64'sd1048576;
    c = alo * 64'sd4294967296 + b;
    return ahi + (c >>> 52);
  endfunction

  function automatic void adapt_taps();
    int nf;
    longint eo, e;
    nf = used_taps();
    for (int j = 0; j < nf; j++)
      for (int r = 0; r < 4; r++) begin
        eo = held_err[r >> 1] * longint'(held_out[r]);
        for (int c = 0; c < 4; c++) begin
          e = eo * longint'(line_mem[nf-j][c]);
          tap_mem[r*4+c][j] = int'(clip(longint'(tap_mem[r*4+c][j]) +
                                        scaled_delta(step_mem[j], e), 24));
        end
      end
  endfunction

  function automatic bit equalise(input eq_req_t q, output eq_res_t r);
    shortint y [4];
    longint px, py;
    bit got;
    r = '0;
    got = 1'b0;
    y = '{default: 0};
    case (q.cmd)
      CMD_SAMPLE: begin
        for (int k = LINE_DEPTH - 1; k > 0; k--) line_mem[k] = line_mem[k-1];
        line_mem[0] = '{q.xr, q.xi, q.yr, q.yi};
        if (held_valid) begin
          fir_out(y);
          r.kind = KIND_TRANS;
          {r.xr, r.xi, r.yr, r.yi} = {y[0], y[1], y[2], y[3]};
          adapt_taps();
          held_valid = 1'b0;
          got = 1'b1;
        end else if (odd_ph && seen_cnt >= ((used_taps() - 1) | 1)) begin
          fir_out(y);
          px = longint'(y[0]) * y[0] + longint'(y[1]) * y[1];
          py = longint'(y[2]) * y[2] + longint'(y[3]) * y[3];
          held_err[0] = ring_error(px);
          held_err[1] = ring_error(py);
          held_out = y;
          held_valid = 1'b1;
          r.kind = KIND_SYMBOL;
          {r.xr, r.xi, r.yr, r.yi} = {y[0], y[1], y[2], y[3]};
          r.ex = held_err[0][ERR_W-1:0];
          r.ey = held_err[1][ERR_W-1:0];
          got = 1'b1;
        end
        if (seen_cnt < MAX_TAPS) seen_cnt++;
        odd_ph = !odd_ph;
      end
      CMD_LOAD_TAP: tap_mem[q.row*4+q.col][q.idx] = q.val;
      CMD_LOAD_STEP: step_mem[q.idx] = shortint'(clip(q.val, 16));
      CMD_LOAD_RADIUS: if (q.idx < MAX_RADII) radius_mem[q.idx] = shortint'(clip(q.val, 16));
      CMD_READ_TAP: begin
        r.kind = KIND_TAP;
        r.tap = TAP_W'(tap_mem[q.row*4+q.col][q.idx]);
        got = 1'b1;
      end
      CMD_RESTART: begin
        line_mem = '{default: '{default: 0}};
        seen_cnt = 0;
        odd_ph = 1'b0;
        held_err = '{0, 0};
        held_out = '{default: 0};
        held_valid = 1'b0;
      end
      default: ;
    endcase
    return got;
  endfunction

  function automatic eq_req_t mk(input logic [CMD_W-1:0] cmd, input int smp, input int row,
                                 input int col, input int idx, input int val);
    eq_req_t q;
    q.cmd = cmd;
    q.xr = smp; q.xi = -smp; q.yr = smp; q.yi = smp;
    q.row = row; q.col = col; q.idx = idx; q.val = val;
    return q;
  endfunction

  function automatic eq_req_t random_req();
    eq_req_t q;
    logic [127:0] bits;
    int pick;
    bits = {$urandom, $urandom, $urandom, $urandom};
    q = bits[$bits(eq_req_t)-1:0];
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      q.xr = $urandom_range(0, 8191) - 4096;
      q.xi = $urandom_range(0, 8191) - 4096;
      q.yr = $urandom_range(0, 8191) - 4096;
      q.yi = $urandom_range(0, 8191) - 4096;
    end
    if ($urandom_range(0, 3) != 0) q.val = $urandom_range(0, 65535) - 32768;
    if (pick < 78) q.cmd = CMD_SAMPLE;
    else if (pick < 84) q.cmd = CMD_LOAD_TAP;
    else if (pick < 87) q.cmd = CMD_LOAD_STEP;
    else if (pick < 90) q.cmd = CMD_LOAD_RADIUS;
    else if (pick < 96) q.cmd = CMD_READ_TAP;
    else if (pick < 98) q.cmd = CMD_RESTART;
    else q.cmd = CMD_W'(CMD_RESTART + 1 + $urandom_range(0, 1));
    return q;
  endfunction

  // offer one request, optionally replacing the computed result with a typed one
  task automatic offer(input eq_req_t q, input bit typed, input eq_res_t typed_res);
    eq_res_t r;
    while ($urandom_range(0, 99) < s_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= q.cmd;
    in_ch.sample_xr <= q.xr;
    in_ch.sample_xi <= q.xi;
    in_ch.sample_yr <= q.yr;
    in_ch.sample_yi <= q.yi;
    in_ch.row <= q.row;
    in_ch.col <= q.col;
    in_ch.entry_index <= q.idx;
    in_ch.load_value <= q.val;
    do @(posedge clk); while (!in_ch.ready);
    if (equalise(q, r)) awaited_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (QUIET_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (index == CFG_TAP_COUNT) tap_cnt = value & 63;
    else radius_cnt = value & 31;
    @(posedge clk);
  endtask

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_TICKS) @(posedge clk);
        hold_req = 1'b0;
      end
      res_ch.ready <= rst_n && ($urandom_range(0, 99) >= r_idle);
    end
  end

  always @(posedge clk) begin
    eq_res_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end else if (rst_n && res_ch.valid && res_ch.ready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind %0d", $realtime, res_ch.kind);
      end else begin
        want = awaited_results.pop_front();
        case (want.kind)
          KIND_SYMBOL: n_symbol++;
          KIND_TRANS: n_trans++;
          default: n_tapread++;
        endcase
        if (res_ch.kind !== want.kind || res_ch.out_xr !== want.xr ||
            res_ch.out_xi !== want.xi || res_ch.out_yr !== want.yr ||
            res_ch.out_yi !== want.yi || res_ch.err_x !== want.ex ||
            res_ch.err_y !== want.ey || res_ch.tap_value !== want.tap) begin
          mismatches++;
          $display("%0t: expected kind %0d out %0d %0d %0d %0d err %0d %0d tap %0d",
                   $realtime, want.kind, want.xr, want.xi, want.yr, want.yi,
                   want.ex, want.ey, want.tap);
          $display("%0t: actual   kind %0d out %0d %0d %0d %0d err %0d %0d tap %0d",
                   $realtime, res_ch.kind, res_ch.out_xr, res_ch.out_xi, res_ch.out_yr,
                   res_ch.out_yi, res_ch.err_x, res_ch.err_y, res_ch.tap_value);
        end
      end
    end
  end

  initial begin
    eq_req_t dir_req [$];
    bit      dir_typed [$];
    eq_res_t dir_res [$];
    eq_res_t tr;
    eq_req_t q;
    int tc_set [PHASES] = '{1, 32, 5, 0, 63, 12};
    int rc_set [PHASES] = '{1, 16, 7, 31, 0, 2};
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_SAMPLE;
    {in_ch.sample_xr, in_ch.sample_xi, in_ch.sample_yr, in_ch.sample_yi} <= '0;
    {in_ch.row, in_ch.col, in_ch.entry_index, in_ch.load_value} <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_TAP_COUNT;
    cfg_ch.data <= '0;
    line_mem = '{default: '{default: 0}};
    tap_mem = '{default: '{default: 0}};
    step_mem = '{default: 0};
    radius_mem = '{default: 0};
    seen_cnt = 0; odd_ph = 1'b0; held_err = '{0, 0};
    held_out = '{default: 0}; held_valid = 1'b0;
    tap_cnt = TAP_COUNT_RST; radius_cnt = RADIUS_COUNT_RST;
    tr = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every tap, step and radius gets written before any sample reads them
    for (int rc = 0; rc < 16; rc++)
      for (int j = 0; j < MAX_TAPS; j++)
        offer(mk(CMD_LOAD_TAP, 0, rc / 4, rc % 4, j,
                 (j == 7 && rc / 4 == rc % 4) ? (1 << 20) : $urandom_range(0, 4095) - 2048),
              1'b0, tr);
    for (int j = 0; j < MAX_TAPS; j++)
      offer(mk(CMD_LOAD_STEP, 0, 0, 0, j, $urandom_range(0, 20000)), 1'b0, tr);
    for (int j = 0; j < MAX_RADII; j++)
      offer(mk(CMD_LOAD_RADIUS, 0, 0, 0, j, $urandom_range(2000, 8000)), 1'b0, tr);

    // directed table: field extremes, ignored commands, saturation, restart
    tr = '0; tr.kind = KIND_TAP;
    dir_req.push_back(mk(CMD_LOAD_TAP, 0, 3, 3, 31, 8388607)); dir_typed.push_back(0);
    dir_res.push_back(tr);
    tr.tap = 8388607;
    dir_req.push_back(mk(CMD_READ_TAP, 0, 3, 3, 31, 0)); dir_typed.push_back(1);
    dir_res.push_back(tr);
    dir_req.push_back(mk(CMD_LOAD_TAP, 0, 0, 0, 0, -8388608)); dir_typed.push_back(0);
    dir_res.push_back(tr);
    tr.tap = -8388608;
    dir_req.push_back(mk(CMD_READ_TAP, 0, 0, 0, 0, 0)); dir_typed.push_back(1);
    dir_res.push_back(tr);
    dir_req.push_back(mk(CMD_LOAD_RADIUS, 0, 0, 0, 20, 1000)); dir_typed.push_back(0);
    dir_res.push_back(tr);
    dir_req.push_back(mk(CMD_LOAD_RADIUS, 0, 0, 0, 0, 8388607)); dir_typed.push_back(0);
    dir_res.push_back(tr);
    dir_req.push_back(mk(CMD_LOAD_RADIUS, 0, 0, 0, 15, -8388608)); dir_typed.push_back(0);
    dir_res.push_back(tr);
    dir_req.push_back(mk(CMD_LOAD_STEP, 0, 0, 0, 31, 8388607)); dir_typed.push_back(0);
    dir_res.push_back(tr);
    dir_req.push_back(mk(CMD_LOAD_STEP, 0, 0, 0, 0, -8388608)); dir_typed.push_back(0);
    dir_res.push_back(tr);
    dir_req.push_back(mk(CMD_RESTART + 1, 0, 1, 2, 3, 4)); dir_typed.push_back(0);
    dir_res.push_back(tr);
    dir_req.push_back(mk(CMD_RESTART + 2, 0, 2, 1, 5, 6)); dir_typed.push_back(0);
    dir_res.push_back(tr);
    for (int k = 0; k < 18; k++) begin
      dir_req.push_back(mk(CMD_SAMPLE, (k % 3 == 0) ? 32767 : (k % 3 == 1) ? -32768 : 0,
                           0, 0, 0, 0));
      dir_typed.push_back(0);
      dir_res.push_back(tr);
    end
    dir_req.push_back(mk(CMD_RESTART, 0, 0, 0, 0, 0)); dir_typed.push_back(0);
    dir_res.push_back(tr);
    dir_req.push_back(mk(CMD_READ_TAP, 0, 1, 2, 7, 0)); dir_typed.push_back(0);
    dir_res.push_back(tr);
    for (int k = 0; k < dir_req.size(); k++) offer(dir_req[k], dir_typed[k], dir_res[k]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_TAP_COUNT, tc_set[p]);
      write_reg(CFG_RADIUS_COUNT, rc_set[p]);
      n_settings++;
      s_idle = (p < 2) ? 29 : (p < 4) ? 65 : 0;
      r_idle = (p < 2) ? 65 : (p < 4) ? 29 : 0;
      if (p == 4) hold_req = 1'b1;
      for (int k = 0; k < PER_PHASE; k++) begin
        q = random_req();
        offer(q, 1'b0, tr);
      end
      drain();
    end

    $display("run covered %0d symbol, %0d transition and %0d tap read results",
             n_symbol, n_trans, n_tapread);
    $display("over %0d register settings with mismatches %0d", n_settings, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
src/mrde_pkg.sv
src/mrde_if.sv
src/mrde_ram.sv
src/mrde_radius.sv
src/mimo_radius_directed_equalizer_core.sv
src/mrde_checker.sv
sim/testbench.sv
